// ===== rtl/chhb_pkg.sv =====
// Package for the chunk header hash builder.
// Holds the hash constants, the chunk size limit, shared types and the mix fold.
// No dependencies.
package chhb_pkg;

  localparam int unsigned MaxChunkBytes = 4096;
  localparam int unsigned CountW        = $clog2(MaxChunkBytes + 1);

  localparam logic [63:0] HashBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] HashMulA  = 64'h00000100000001B3;
  localparam logic [63:0] HashMulB  = 64'hff51afd7ed558ccd;
  localparam int unsigned HashShift = 33;
  localparam logic [31:0] MagicPhnx = 32'h50484E58;

  typedef logic [63:0] word64_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_EMIT
  } state_t;

  function automatic word64_t fold33(word64_t v);
    return v ^ (v >> HashShift);
  endfunction

endpackage

// ===== rtl/chhb_mul.sv =====
// Iterative 64x64 multiplier, low 64 bits of the product.
// One shared 32x32 multiplier: lo*lo, lo*hi, hi*lo; done pulses on final product.
// Depends on chhb_pkg.
module chhb_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  chhb_pkg::word64_t a,
  input  chhb_pkg::word64_t b,
  output logic             done,
  output chhb_pkg::word64_t product
);
  import chhb_pkg::*;

  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepHiLo = 2'd2;

  word64_t     opa;
  word64_t     opb;
  word64_t     acc;
  logic [1:0]  step;
  logic        run;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] p;

  always_comb begin
    case (step)
      StepLoLo: begin
        x = opa[31:0];
        y = opb[31:0];
      end
      StepLoHi: begin
        x = opa[31:0];
        y = opb[63:32];
      end
      default: begin
        x = opa[63:32];
        y = opb[31:0];
      end
    endcase
    p = 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= StepLoLo;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= StepLoLo;
      end else if (run) begin
        if (step == StepHiLo) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
      opb <= b;
    end
    if (run) begin
      if (step == StepLoLo) begin
        acc <= p;
      end else begin
        acc[63:32] <= acc[63:32] + p[31:0];
      end
    end
  end

  assign product = acc;

endmodule

// ===== rtl/chunk_header_hash_builder.sv =====
// Chunk header hash builder, top level.
// Hashes a stream of payload bytes and emits one header word per chunk.
// Depends on chhb_pkg and chhb_mul.
//
// Input channel: one word per cycle at most, accepted when in_valid is high
// and in_stall is low. A word with byte_valid set is absorbed into the 64-bit
// hash and the byte count; a word with last_item set closes the chunk.
// Output channel: one header word per chunk (magic, sequence, total, count,
// checksum, overflow flag), handed over when out_valid is high and out_stall
// is low. The header sits in an output register, so input keeps flowing.
//
// Timing: a word carrying a payload byte holds in_stall high until the hash
// has absorbed it, so the next word waits; each byte needs two 64x64
// multiplies on the shared 32x32 multiplier, the second started by the
// first one's done. A word with neither byte nor last mark is not stalled.
// The header is loaded from the emit step, entered as the last byte's hash
// is stored (or on acceptance of a closing word with no byte). If the
// previous header is still stalled, the block waits in emit until it is taken.
// Reset (rst, synchronous): hash to offset basis, count and flag cleared,
// no header pending. Hash, count and flag are cleared again at each header.
module chunk_header_hash_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last_item,
  input  logic [31:0] seq_number,
  input  logic [31:0] chunk_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] magic_word,
  output logic [31:0] header_seq,
  output logic [31:0] header_total,
  output logic [12:0] byte_count,
  output logic [63:0] checksum,
  output logic        size_overflow
);
  import chhb_pkg::*;

  state_t             state;
  state_t             state_next;
  word64_t            hash;
  logic [CountW-1:0]  bytes_seen;
  logic               overflow_seen;
  logic               last_q;
  logic [31:0]        seq_q;
  logic [31:0]        total_q;

  logic    accept;
  logic    out_load;
  logic    mul_start;
  word64_t mul_a;
  word64_t mul_b;
  logic    mul_done;
  word64_t mul_p;

  chhb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (byte_valid) begin
            state_next = ST_MUL_A;
          end else if (last_item) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL_A: begin
        if (mul_done) begin
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mul_done) begin
          state_next = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    accept    = in_valid && !in_stall;
    out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
    mul_start = 1'b0;
    mul_a     = fold33(mul_p);
    mul_b     = HashMulB;
    unique case (state)
      ST_IDLE: begin
        mul_start = accept && byte_valid;
        mul_a     = hash ^ {56'd0, data_byte};
        mul_b     = HashMulA;
      end
      ST_MUL_A: begin
        mul_start = mul_done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hash          <= HashBasis;
      bytes_seen    <= '0;
      overflow_seen <= 1'b0;
      last_q        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_q <= last_item;
        if (byte_valid) begin
          if (bytes_seen >= CountW'(MaxChunkBytes)) begin
            overflow_seen <= 1'b1;
          end else begin
            bytes_seen <= bytes_seen + CountW'(1);
          end
        end
      end
      if (state == ST_MUL_B && mul_done) begin
        hash <= fold33(mul_p);
      end
      if (out_load) begin
        hash          <= HashBasis;
        bytes_seen    <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q   <= seq_number;
      total_q <= chunk_total;
    end
    if (out_load) begin
      magic_word    <= MagicPhnx;
      header_seq    <= seq_q;
      header_total  <= total_q;
      byte_count    <= 13'(bytes_seen);
      checksum      <= hash;
      size_overflow <= overflow_seen;
    end
  end

endmodule

// ===== rtl/chhb_checker.sv =====
// Port-level checker for the chunk header hash builder, bound to the top level.
// Depends on chhb_pkg.
module chhb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        byte_valid,
  input logic        last_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] magic_word,
  input logic [12:0] byte_count,
  input logic [63:0] checksum
);
  import chhb_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("header or busy state survived reset");

  a_ignored_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !byte_valid && !last_item |=> !in_stall)
    else $error("empty word without last mark stalled the input");

  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && byte_valid |=> in_stall)
    else $error("payload byte accepted without busy period");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count <= 13'(MaxChunkBytes)) && magic_word == MagicPhnx)
    else $error("header count above chunk limit or bad magic");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(checksum) && $stable(byte_count))
    else $error("stalled header changed");

endmodule

bind chunk_header_hash_builder chhb_checker u_chhb_checker (.*);

// ===== verif/chunk_header_hash_builder_tb.sv =====
// Testbench for chunk_header_hash_builder: streams payload words, predicts each chunk header
// with its own hash and byte counter, and compares every header field on the output channel.
// Depends on chhb_pkg and the chunk_header_hash_builder RTL.
module chunk_header_hash_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] PRIME_MUL    = 64'h00000100000001B3;
  localparam logic [63:0] FINAL_MUL    = 64'hff51afd7ed558ccd;
  localparam int          FOLD_SHIFT   = 33;
  localparam logic [31:0] PHNX_MAGIC   = 32'h50484E58;
  localparam int          CHUNK_LIMIT  = chhb_pkg::MaxChunkBytes;

  typedef struct {
    logic [31:0] magic;
    logic [31:0] seq;
    logic [31:0] total;
    logic [12:0] count;
    logic [63:0] sum;
    logic        ovf;
  } chunk_header_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        last_item = 1'b0;
  logic [31:0] seq_number = '0;
  logic [31:0] chunk_total = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] magic_word;
  logic [31:0] header_seq;
  logic [31:0] header_total;
  logic [12:0] byte_count;
  logic [63:0] checksum;
  logic        size_overflow;

  chunk_header_hash_builder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_valid(byte_valid), .last_item(last_item),
    .seq_number(seq_number), .chunk_total(chunk_total),
    .out_valid(out_valid), .out_stall(out_stall),
    .magic_word(magic_word), .header_seq(header_seq), .header_total(header_total),
    .byte_count(byte_count), .checksum(checksum), .size_overflow(size_overflow)
  );

  chunk_header_t pending_headers[$];
  logic [63:0]   chunk_hash = OFFSET_BASIS;
  int            chunk_bytes = 0;
  logic          chunk_overflow = 1'b0;
  int            err_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_req = 0;
  int            hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] hash_absorb(logic [63:0] h, logic [7:0] b);
    h = h ^ {56'd0, b};
    h = h * PRIME_MUL;
    h = h ^ (h >> FOLD_SHIFT);
    h = h * FINAL_MUL;
    h = h ^ (h >> FOLD_SHIFT);
    return h;
  endfunction

  // header prediction on each accepted input word
  always @(posedge clk) begin
    chunk_header_t hdr;
    if (rst) begin
      chunk_hash = OFFSET_BASIS;
      chunk_bytes = 0;
      chunk_overflow = 1'b0;
    end else if (in_valid && !in_stall) begin
      if (byte_valid) begin
        chunk_hash = hash_absorb(chunk_hash, data_byte);
        if (chunk_bytes >= CHUNK_LIMIT) chunk_overflow = 1'b1;
        else chunk_bytes++;
      end
      if (last_item) begin
        hdr.magic = PHNX_MAGIC;
        hdr.seq = seq_number;
        hdr.total = chunk_total;
        hdr.count = chunk_bytes[12:0];
        hdr.sum = chunk_hash;
        hdr.ovf = chunk_overflow;
        pending_headers.push_back(hdr);
        chunk_hash = OFFSET_BASIS;
        chunk_bytes = 0;
        chunk_overflow = 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    chunk_header_t hdr;
    if (!rst && out_valid && !out_stall) begin
      if (pending_headers.size() == 0) begin
        $error("header word with none expected: seq %h", header_seq);
        err_count++;
      end else begin
        hdr = pending_headers.pop_front();
        check_field("magic_word", 64'(hdr.magic), 64'(magic_word));
        check_field("header_seq", 64'(hdr.seq), 64'(header_seq));
        check_field("header_total", 64'(hdr.total), 64'(header_total));
        check_field("byte_count", 64'(hdr.count), 64'(byte_count));
        check_field("checksum", hdr.sum, checksum);
        check_field("size_overflow", 64'(hdr.ovf), 64'(size_overflow));
      end
    end
  end

  // receiver: long hold-off on request, random stall otherwise
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic send_word(logic [7:0] b, logic bv, logic last, logic [31:0] seq,
                           logic [31:0] tot);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_valid <= bv;
    last_item <= last;
    seq_number <= seq;
    chunk_total <= tot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_payload_byte(logic [7:0] b);
    send_word(b, 1'b1, 1'b0, $urandom, $urandom);
  endtask

  task automatic wait_headers_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_headers.size() != 0) @(posedge clk);
  endtask

  // returns the number of counted words sent (ignored words excluded)
  task automatic send_random_chunk(output int sent);
    int len;
    len = ($urandom_range(9, 0) < 8) ? $urandom_range(6, 0) : $urandom_range(40, 0);
    sent = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9, 0) == 0)
        send_word(8'($urandom_range(255, 0)), 1'b0, 1'b0, $urandom, $urandom);
      send_payload_byte(8'($urandom_range(255, 0)));
      sent++;
    end
    send_word(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1,
              $urandom, $urandom);
    sent++;
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(8'h00, 1'b0, 1'b1, 32'h0, 32'h0);
    send_word(8'h00, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_payload_byte(8'hFF);
    send_word(8'hFF, 1'b0, 1'b1, 32'h0, 32'hFFFFFFFF);
    send_word(8'h33, 1'b0, 1'b0, 32'h1, 32'h2);
    send_payload_byte(8'hA5);
    send_word(8'hCC, 1'b0, 1'b0, 32'hFFFFFFFF, 32'h0);
    send_word(8'h5A, 1'b1, 1'b1, 32'h80000001, 32'h7FFFFFFE);
    send_payload_byte(8'h01);
    send_payload_byte(8'h80);
    send_payload_byte(8'h7F);
    send_payload_byte(8'hFE);
    send_word(8'h00, 1'b0, 1'b1, 32'h12345678, 32'h9ABCDEF0);
    wait_headers_drained();
  endtask

  // exactly full chunk, then one that saturates, then a short one to see the flag clear
  task automatic test_size_limit();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < CHUNK_LIMIT; i++) send_payload_byte(8'($urandom_range(255, 0)));
    send_word(8'h00, 1'b0, 1'b1, $urandom, $urandom);
    for (int i = 0; i < CHUNK_LIMIT + 1; i++) send_payload_byte(8'($urandom_range(255, 0)));
    send_word(8'($urandom_range(255, 0)), 1'b1, 1'b1, $urandom, $urandom);
    send_payload_byte(8'h42);
    send_word(8'h00, 1'b0, 1'b1, $urandom, $urandom);
    wait_headers_drained();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_words);
    int total_sent;
    int sent;
    total_sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (total_sent < n_words) begin
      send_random_chunk(sent);
      total_sent += sent;
    end
    wait_headers_drained();
  endtask

  // receiver holds off while short chunks keep coming, so the input channel backs up
  task automatic test_backpressure();
    int sent;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 300;
    for (int i = 0; i < 8; i++) begin
      send_payload_byte(8'($urandom_range(255, 0)));
      send_word(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1,
                $urandom, $urandom);
    end
    for (int i = 0; i < 4; i++) send_random_chunk(sent);
    wait_headers_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_limit();
    test_random_traffic(0, 0, 100);
    test_random_traffic(84, 0, 100);
    test_random_traffic(0, 84, 100);
    test_random_traffic(38, 38, 100);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_headers_drained();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("chunk_header_hash_builder_tb: done, clean");
    end else begin
      $display("chunk_header_hash_builder_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("chunk_header_hash_builder_tb: done, errors");
    $finish;
  end

endmodule
